// ===== rtl/rvdec_pkg.sv =====
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and encodings for the RV32I instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 6;
  localparam int unsigned FmtW  = 3;
  localparam int unsigned RegW  = 5;
  localparam int unsigned F3W   = 3;
  localparam int unsigned F7W   = 7;
  localparam int unsigned OpcW  = 7;

  typedef enum logic [OpcW-1:0] {
    OPC_LOAD   = 7'b0000011,
    OPC_IMM    = 7'b0010011,
    OPC_AUIPC  = 7'b0010111,
    OPC_STORE  = 7'b0100011,
    OPC_REG    = 7'b0110011,
    OPC_LUI    = 7'b0110111,
    OPC_BRANCH = 7'b1100011,
    OPC_JALR   = 7'b1100111,
    OPC_JAL    = 7'b1101111,
    OPC_SYSTEM = 7'b1110011
  } opcode_e;

  typedef enum logic [FmtW-1:0] {
    FMT_R   = 3'd0,
    FMT_I   = 3'd1,
    FMT_S   = 3'd2,
    FMT_B   = 3'd3,
    FMT_U   = 3'd4,
    FMT_J   = 3'd5,
    FMT_SYS = 3'd6
  } fmt_e;

  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 6'd0,
    KIND_ADD   = 6'd1,
    KIND_SUB   = 6'd2,
    KIND_XOR   = 6'd3,
    KIND_OR    = 6'd4,
    KIND_AND   = 6'd5,
    KIND_SLL   = 6'd6,
    KIND_SRL   = 6'd7,
    KIND_SRA   = 6'd8,
    KIND_SLT   = 6'd9,
    KIND_SLTU  = 6'd10,
    KIND_LB    = 6'd11,
    KIND_LH    = 6'd12,
    KIND_LW    = 6'd13,
    KIND_LBU   = 6'd14,
    KIND_LHU   = 6'd15,
    KIND_ADDI  = 6'd16,
    KIND_SLLI  = 6'd17,
    KIND_SLTI  = 6'd18,
    KIND_SLTIU = 6'd19,
    KIND_XORI  = 6'd20,
    KIND_SRLI  = 6'd21,
    KIND_SRAI  = 6'd22,
    KIND_ORI   = 6'd23,
    KIND_ANDI  = 6'd24,
    KIND_JALR  = 6'd25,
    KIND_BEQ   = 6'd26,
    KIND_BNE   = 6'd27,
    KIND_BLT   = 6'd28,
    KIND_BGE   = 6'd29,
    KIND_BLTU  = 6'd30,
    KIND_BGEU  = 6'd31,
    KIND_SB    = 6'd32,
    KIND_SH    = 6'd33,
    KIND_SW    = 6'd34,
    KIND_JAL   = 6'd35,
    KIND_LUI   = 6'd36,
    KIND_AUIPC = 6'd37,
    KIND_ECALL = 6'd38
  } kind_e;

  localparam logic [F7W-1:0]   F7_BASE    = 7'b0000000;
  localparam logic [F7W-1:0]   F7_ALT     = 7'b0100000;
  localparam logic [WordW-1:0] ECALL_WORD = 32'h0000_0073;

  typedef struct packed {
    kind_e              kind;
    fmt_e               fmt;
    logic [RegW-1:0]    rd;
    logic [RegW-1:0]    rs1;
    logic [RegW-1:0]    rs2;
    logic [F3W-1:0]     f3;
    logic [WordW-1:0]   imm;
  } dec_t;

endpackage

// ===== rtl/rvdec_decode.sv =====
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational RV32I decode: instruction class, operand fields, immediate.
// ----------------------------------------------------------------------------
module rvdec_decode
  import rvdec_pkg::*;
(
  input  logic [WordW-1:0] word_i,
  output dec_t             dec_o
);

  logic [OpcW-1:0]  opc;
  logic [RegW-1:0]  rd, rs1, rs2;
  logic [F3W-1:0]   f3;
  logic [F7W-1:0]   f7;
  logic [WordW-1:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  kind_e            kind;
  fmt_e             fmt;
  logic [WordW-1:0] imm;
  logic             use_rd, use_rs1, use_rs2, use_f3;

  assign opc = word_i[6:0];
  assign rd  = word_i[11:7];
  assign f3  = word_i[14:12];
  assign rs1 = word_i[19:15];
  assign rs2 = word_i[24:20];
  assign f7  = word_i[31:25];

  assign imm_i = {{20{word_i[31]}}, word_i[31:20]};
  assign imm_s = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
  assign imm_b = {{19{word_i[31]}}, word_i[31], word_i[7], word_i[30:25], word_i[11:8], 1'b0};
  assign imm_u = {word_i[31:12], 12'b0};
  assign imm_j = {{11{word_i[31]}}, word_i[31], word_i[19:12], word_i[20], word_i[30:21],
                  1'b0};

  always_comb begin
    kind    = KIND_NONE;
    fmt     = FMT_R;
    imm     = '0;
    use_rd  = 1'b0;
    use_rs1 = 1'b0;
    use_rs2 = 1'b0;
    use_f3  = 1'b0;
    unique case (opc)
      OPC_REG: begin
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
        use_f3  = 1'b1;
        if (f7 == F7_BASE) begin
          unique case (f3)
            3'd0: kind = KIND_ADD;
            3'd1: kind = KIND_SLL;
            3'd2: kind = KIND_SLT;
            3'd3: kind = KIND_SLTU;
            3'd4: kind = KIND_XOR;
            3'd5: kind = KIND_SRL;
            3'd6: kind = KIND_OR;
            default: kind = KIND_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          kind = KIND_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          kind = KIND_SRA;
        end
      end
      OPC_LOAD: begin
        fmt     = FMT_I;
        imm     = imm_i;
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        use_f3  = 1'b1;
        unique case (f3)
          3'd0: kind = KIND_LB;
          3'd1: kind = KIND_LH;
          3'd2: kind = KIND_LW;
          3'd4: kind = KIND_LBU;
          3'd5: kind = KIND_LHU;
          default: kind = KIND_NONE;
        endcase
      end
      OPC_IMM: begin
        fmt     = FMT_I;
        imm     = imm_i;
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        use_f3  = 1'b1;
        unique case (f3)
          3'd0: kind = KIND_ADDI;
          3'd1: kind = (f7 == F7_BASE) ? KIND_SLLI : KIND_NONE;
          3'd2: kind = KIND_SLTI;
          3'd3: kind = KIND_SLTIU;
          3'd4: kind = KIND_XORI;
          3'd5: kind = (f7 == F7_BASE) ? KIND_SRLI :
                       (f7 == F7_ALT)  ? KIND_SRAI : KIND_NONE;
          3'd6: kind = KIND_ORI;
          default: kind = KIND_ANDI;
        endcase
      end
      OPC_JALR: begin
        fmt     = FMT_I;
        imm     = imm_i;
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        use_f3  = 1'b1;
        kind    = (f3 == 3'd0) ? KIND_JALR : KIND_NONE;
      end
      OPC_BRANCH: begin
        fmt     = FMT_B;
        imm     = imm_b;
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
        use_f3  = 1'b1;
        unique case (f3)
          3'd0: kind = KIND_BEQ;
          3'd1: kind = KIND_BNE;
          3'd4: kind = KIND_BLT;
          3'd5: kind = KIND_BGE;
          3'd6: kind = KIND_BLTU;
          3'd7: kind = KIND_BGEU;
          default: kind = KIND_NONE;
        endcase
      end
      OPC_STORE: begin
        fmt     = FMT_S;
        imm     = imm_s;
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
        use_f3  = 1'b1;
        unique case (f3)
          3'd0: kind = KIND_SB;
          3'd1: kind = KIND_SH;
          3'd2: kind = KIND_SW;
          default: kind = KIND_NONE;
        endcase
      end
      OPC_JAL: begin
        kind   = KIND_JAL;
        fmt    = FMT_J;
        imm    = imm_j;
        use_rd = 1'b1;
      end
      OPC_LUI: begin
        kind   = KIND_LUI;
        fmt    = FMT_U;
        imm    = imm_u;
        use_rd = 1'b1;
      end
      OPC_AUIPC: begin
        kind   = KIND_AUIPC;
        fmt    = FMT_U;
        imm    = imm_u;
        use_rd = 1'b1;
      end
      OPC_SYSTEM: begin
        if (word_i == ECALL_WORD) begin
          kind = KIND_ECALL;
          fmt  = FMT_SYS;
        end
      end
      default: kind = KIND_NONE;
    endcase

    // unrecognized encodings report all-zero fields
    if (kind == KIND_NONE) begin
      fmt     = FMT_R;
      imm     = '0;
      use_rd  = 1'b0;
      use_rs1 = 1'b0;
      use_rs2 = 1'b0;
      use_f3  = 1'b0;
    end
  end

  assign dec_o.kind = kind;
  assign dec_o.fmt  = fmt;
  assign dec_o.rd   = use_rd  ? rd  : '0;
  assign dec_o.rs1  = use_rs1 ? rs1 : '0;
  assign dec_o.rs2  = use_rs2 ? rs2 : '0;
  assign dec_o.f3   = use_f3  ? f3  : '0;
  assign dec_o.imm  = imm;

endmodule

// ===== rtl/rv32i_instruction_decoder_top.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_top
// RV32I instruction decoder with registered input and registered result.
// ----------------------------------------------------------------------------
// One instruction word per request, one request every clock cycle: busy stays
// low, so start may be held high continuously. The word is captured in an input
// register, decoded by a short combinational stage and captured in the result
// register. These two registers set the latency. done_o is high for one cycle
// per request; it is carried by the in_vld_q and done_q registers in step with
// the input and result registers, so the result is taken while done_o is high.
// The decoded fields are valid in that cycle only. The receiver cannot stall;
// results arrive in request order, one per request.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [WordW-1:0]        instr_word_i,
  output logic                    done_o,
  output logic [KindW-1:0]        instr_kind_o,
  output logic [FmtW-1:0]         format_class_o,
  output logic [RegW-1:0]         dest_reg_o,
  output logic [RegW-1:0]         src_reg_a_o,
  output logic [RegW-1:0]         src_reg_b_o,
  output logic [F3W-1:0]          func_sel_o,
  output logic signed [WordW-1:0] immediate_o
);

  logic             in_vld_q, in_vld_d;
  logic [WordW-1:0] word_q;
  logic             done_q;
  dec_t             dec;
  dec_t             res_q;

  assign busy     = 1'b0;
  assign in_vld_d = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      done_q   <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_d) begin
      word_q <= instr_word_i;
    end
    if (in_vld_q) begin
      res_q <= dec;
    end
  end

  rvdec_decode u_decode (
    .word_i (word_q),
    .dec_o  (dec)
  );

  assign done_o         = done_q;
  assign instr_kind_o   = res_q.kind;
  assign format_class_o = res_q.fmt;
  assign dest_reg_o     = res_q.rd;
  assign src_reg_a_o    = res_q.rs1;
  assign src_reg_b_o    = res_q.rs2;
  assign func_sel_o     = res_q.f3;
  assign immediate_o    = $signed(res_q.imm);

  a_req_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("request produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> ##1 !done_o)
    else $error("result without request");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && instr_kind_o == KIND_NONE) |->
      (format_class_o == FMT_R && immediate_o == '0 && dest_reg_o == '0 &&
       src_reg_a_o == '0 && src_reg_b_o == '0 && func_sel_o == '0))
    else $error("unrecognized instruction with nonzero fields");

  a_branch_imm_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (format_class_o == FMT_B || format_class_o == FMT_J)) |->
      (immediate_o[0] == 1'b0 && dest_reg_o == '0) || format_class_o == FMT_J)
    else $error("branch/jump immediate or branch rd malformed");

endmodule
